// ===== rtl/tcp_flag_scan_detector_unit_assert.svh =====
// Assertion macros shared by the scan detector RTL
`ifndef TCP_FLAG_SCAN_DETECTOR_UNIT_ASSERT_SVH
`define TCP_FLAG_SCAN_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TFSD_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfsd assertion failed");

// next-cycle implication
`define TFSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfsd assertion failed");

`endif

// ===== rtl/tfsd_pkg.sv =====
// Shared types and constants of the TCP flag scan detector
package tfsd_pkg;

  localparam int FLOW_W  = 10;
  localparam int FLAGS_W = 8;
  localparam int EVID_W  = 16;
  localparam int PAT_W   = 2;
  localparam int THR_W   = 16;
  localparam int NUM_PAT = 4;
  localparam int ADDR_W  = 4;

  // flag masks and match values
  localparam logic [FLAGS_W-1:0] SYN_ACK_MASK = 8'h12;
  localparam logic [FLAGS_W-1:0] SYN_ONLY     = 8'h02;
  localparam logic [FLAGS_W-1:0] FIN_ACK_MASK = 8'h11;
  localparam logic [FLAGS_W-1:0] FIN_ONLY     = 8'h01;
  localparam logic [FLAGS_W-1:0] XMAS_MASK    = 8'h29;
  localparam logic [FLAGS_W-1:0] NULL_FLAGS   = 8'h00;

  // alert patterns, also the bit index in the fired mask
  localparam logic [PAT_W-1:0] PAT_SYN_FLOOD = 2'd0;
  localparam logic [PAT_W-1:0] PAT_NULL_SCAN = 2'd1;
  localparam logic [PAT_W-1:0] PAT_XMAS_SCAN = 2'd2;
  localparam logic [PAT_W-1:0] PAT_FIN_SCAN  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SYN_THR  = 2'd0;
  localparam logic [1:0] REG_NULL_THR = 2'd1;
  localparam logic [1:0] REG_XMAS_THR = 2'd2;

  localparam logic [THR_W-1:0] SYN_THR_RST  = 16'd20;
  localparam logic [THR_W-1:0] NULL_THR_RST = 16'd1;
  localparam logic [THR_W-1:0] XMAS_THR_RST = 16'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [THR_W-1:0] syn;
    logic [THR_W-1:0] nul;
    logic [THR_W-1:0] xmas;
  } thr_t;

  // alerts raised by one packet
  typedef struct packed {
    logic [FLOW_W-1:0]                flow;
    logic [NUM_PAT-1:0]               fire;
    logic [NUM_PAT-1:0][EVID_W-1:0]   evid;
  } alert_rec_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

// ===== rtl/tfsd_if.sv =====
// Packet and alert channel interfaces
interface tfsd_in_if;
  import tfsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FLOW_W-1:0]  flow_index;
  logic [FLAGS_W-1:0] tcp_flags;
  logic               flow_start;

  modport source (output valid, flow_index, tcp_flags, flow_start, input ready);
  modport sink   (input valid, flow_index, tcp_flags, flow_start, output ready);
endinterface

interface tfsd_out_if;
  import tfsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] alert_flow;
  logic [PAT_W-1:0]  pattern;
  logic              severity;
  logic [EVID_W-1:0] evidence_count;
  logic              last;

  modport source (output valid, alert_flow, pattern, severity, evidence_count, last,
                  input ready);
  modport sink   (input valid, alert_flow, pattern, severity, evidence_count, last,
                  output ready);
endinterface

// ===== rtl/tcp_flag_scan_detector_unit.sv =====
// Top level of the TCP flag scan detector
//
//   channel   dir   beat                                              handshake
//   pkt       in    flow_index, tcp_flags, flow_start                 valid/ready
//   alert     out   alert_flow, pattern, severity, evidence_count,    valid/ready
//                   last
//   apb       in    threshold registers at 0x0, 0x4, 0x8              psel/penable
//
// One packet accepted per cycle unless clearing or a full queue stalls the pipeline; each
// packet does one read-modify-write of its flow entry (one read and one write port on the
// flow table), so the table sets the rate. A packet passes the s0 and s1 registers, the
// alert queue and the output register before its first alert beat; a packet raising k
// alerts gives k beats on the alert port. After reset a clearing pass zeroes the table
// with pkt.ready low. A 4-record queue and an output register decouple the sides.
module tcp_flag_scan_detector_unit #(
  parameter int FLOW_ENTRIES = 1024,
  parameter int COUNT_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  tfsd_in_if.sink                     pkt,
  tfsd_out_if.source                  alert,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfsd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tfsd_pkg::*;

  thr_t       thr;
  qstat_t     qstat;
  alert_rec_t push_rec;
  alert_rec_t head;
  logic       push;
  logic       pop;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= {SYN_THR_RST, NULL_THR_RST, XMAS_THR_RST};
    end else if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_SYN_THR:  thr.syn  <= pwdata[THR_W-1:0];
        REG_NULL_THR: thr.nul  <= pwdata[THR_W-1:0];
        REG_XMAS_THR: thr.xmas <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_SYN_THR:  prdata = {16'b0, thr.syn};
      REG_NULL_THR: prdata = {16'b0, thr.nul};
      REG_XMAS_THR: prdata = {16'b0, thr.xmas};
      default:      prdata = '0;
    endcase
  end

  tfsd_front #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .pkt   (pkt),
    .thr   (thr),
    .qstat (qstat),
    .push  (push),
    .rec   (push_rec)
  );

  tfsd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .head   (head),
    .stat   (qstat)
  );

  tfsd_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .qstat (qstat),
    .head  (head),
    .pop   (pop),
    .alert (alert)
  );

endmodule

// ===== rtl/tfsd_front.sv =====
// Front end: packet intake, flag classification and flow table update
`include "tcp_flag_scan_detector_unit_assert.svh"
module tfsd_front #(
  parameter int FLOW_ENTRIES = 1024,
  parameter int COUNT_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  tfsd_in_if.sink             pkt,
  input  tfsd_pkg::thr_t      thr,
  input  tfsd_pkg::qstat_t    qstat,
  output logic                push,
  output tfsd_pkg::alert_rec_t rec
);
  import tfsd_pkg::*;

  localparam int SLOT_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(FLOW_ENTRIES - 1);
  localparam int RCP_SH = 2 * FLOW_W;
  localparam logic [RCP_SH-1:0] RCP = RCP_SH'((1 << RCP_SH) / FLOW_ENTRIES);

  typedef struct packed {
    logic [COUNT_BITS-1:0] syn;
    logic [COUNT_BITS-1:0] fin;
    logic [COUNT_BITS-1:0] nul;
    logic [COUNT_BITS-1:0] xmas;
    logic                  hs;
    logic [NUM_PAT-1:0]    fired;
  } entry_t;

  typedef struct packed {
    logic syn;
    logic fin;
    logic nul;
    logic xmas;
    logic synack;
  } cls_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [FLOW_W-1:0] f);
    logic [3*FLOW_W-1:0] prod;
    logic [FLOW_W-1:0]   q;
    logic [2*FLOW_W-1:0] qn;
    logic [FLOW_W-1:0]   r;
    if (FLOW_ENTRIES >= (1 << FLOW_W)) begin
      return SLOT_W'(f);
    end
    // reciprocal multiply; the quotient estimate is low by at most one
    prod = (3*FLOW_W)'(f) * (3*FLOW_W)'(RCP);
    q    = prod[3*FLOW_W-1:RCP_SH];
    qn   = (2*FLOW_W)'(q) * (2*FLOW_W)'(FLOW_ENTRIES);
    r    = f - qn[FLOW_W-1:0];
    if (r >= FLOW_W'(FLOW_ENTRIES)) begin
      r = r - FLOW_W'(FLOW_ENTRIES);
    end
    return SLOT_W'(r);
  endfunction

  function automatic cls_t classify(input logic [FLAGS_W-1:0] fl);
    cls_t c;
    c.syn    = (fl & SYN_ACK_MASK) == SYN_ONLY;
    c.fin    = (fl & FIN_ACK_MASK) == FIN_ONLY;
    c.nul    = fl == NULL_FLAGS;
    c.xmas   = (fl & XMAS_MASK) == XMAS_MASK;
    c.synack = (fl & SYN_ACK_MASK) == SYN_ACK_MASK;
    return c;
  endfunction

  function automatic logic [EVID_W-1:0] sat_evid(input logic [COUNT_BITS-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return (w > CMP_W'(16'hFFFF)) ? 16'hFFFF : w[EVID_W-1:0];
  endfunction

  entry_t mem [FLOW_ENTRIES];

  logic              clearing;
  logic [SLOT_W-1:0] clr_idx;

  logic              s0_valid;
  logic [FLOW_W-1:0] s0_flow;
  logic [SLOT_W-1:0] s0_slot;
  logic              s0_start;
  cls_t              s0_cls;

  logic              s1_valid;
  logic [FLOW_W-1:0] s1_flow;
  logic [SLOT_W-1:0] s1_slot;
  logic              s1_start;
  cls_t              s1_cls;
  logic              fwd;

  entry_t rd_data, last_wr, old, upd;
  logic [NUM_PAT-1:0] cond, fire;
  logic accept, s0_move, s1_move;

  assign s1_move   = s1_valid && !qstat.full;
  assign s0_move   = s0_valid && (!s1_valid || s1_move);
  assign pkt.ready = !clearing && (!s0_valid || s0_move);
  assign accept    = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SLOT_W'(1);
        if (clr_idx == SLOT_TOP) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        s0_valid <= 1'b1;
      end else if (s0_move) begin
        s0_valid <= 1'b0;
      end
      if (s0_move) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_flow  <= pkt.flow_index;
      s0_slot  <= slot_of(pkt.flow_index);
      s0_start <= pkt.flow_start;
      s0_cls   <= classify(pkt.tcp_flags);
    end
    if (s0_move) begin
      s1_flow  <= s0_flow;
      s1_slot  <= s0_slot;
      s1_start <= s0_start;
      s1_cls   <= s0_cls;
      // the entry being written this edge is not yet in the read data
      fwd      <= s1_move && (s1_slot == s0_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && clearing) begin
      mem[clr_idx] <= '0;
    end else if (s1_move) begin
      mem[s1_slot] <= upd;
    end
    if (s0_move) begin
      rd_data <= mem[s0_slot];
    end
    if (s1_move) begin
      last_wr <= upd;
    end
  end

  always_comb begin
    old = s1_start ? '0 : (fwd ? last_wr : rd_data);
    upd = old;
    if (s1_cls.syn && old.syn != CNT_MAX) begin
      upd.syn = old.syn + COUNT_BITS'(1);
    end
    if (s1_cls.fin && old.fin != CNT_MAX) begin
      upd.fin = old.fin + COUNT_BITS'(1);
    end
    if (s1_cls.nul && old.nul != CNT_MAX) begin
      upd.nul = old.nul + COUNT_BITS'(1);
    end
    if (s1_cls.xmas && old.xmas != CNT_MAX) begin
      upd.xmas = old.xmas + COUNT_BITS'(1);
    end
    if (s1_cls.synack) begin
      upd.hs = 1'b1;
    end
    cond[PAT_SYN_FLOOD] = (CMP_W'(upd.syn) >= CMP_W'(thr.syn)) && !upd.hs;
    cond[PAT_NULL_SCAN] = CMP_W'(upd.nul) >= CMP_W'(thr.nul);
    cond[PAT_XMAS_SCAN] = CMP_W'(upd.xmas) >= CMP_W'(thr.xmas);
    cond[PAT_FIN_SCAN]  = (upd.fin != '0) && !upd.hs && (upd.syn == '0);
    fire      = cond & ~old.fired;
    upd.fired = old.fired | cond;
  end

  always_comb begin
    rec.flow                = s1_flow;
    rec.fire                = fire;
    rec.evid[PAT_SYN_FLOOD] = sat_evid(upd.syn);
    rec.evid[PAT_NULL_SCAN] = sat_evid(upd.nul);
    rec.evid[PAT_XMAS_SCAN] = sat_evid(upd.xmas);
    rec.evid[PAT_FIN_SCAN]  = sat_evid(upd.fin);
  end

  assign push = s1_move && (fire != '0);

  `TFSD_ASSERT_IMPL(a_push_not_full, clk, rst, push, !qstat.full)
  `TFSD_ASSERT_IMPL(a_idle_while_clear, clk, rst, clearing, !s0_valid && !s1_valid)
  `TFSD_ASSERT_IMPL(a_clear_ends_at_top, clk, rst, $fell(clearing), $past(clr_idx) == SLOT_TOP)

endmodule

// ===== rtl/tfsd_queue.sv =====
// Short alert record queue between front end and emitter
module tfsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tfsd_pkg::alert_rec_t wr_rec,
  input  logic                 pop,
  output tfsd_pkg::alert_rec_t head,
  output tfsd_pkg::qstat_t     stat
);
  import tfsd_pkg::*;

  alert_rec_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.valid = count != '0;
  assign stat.full  = count == (QPTR_W+1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

endmodule

// ===== rtl/tfsd_emit.sv =====
// Back end: splits alert records into output beats, one pattern per beat
`include "tcp_flag_scan_detector_unit_assert.svh"
module tfsd_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  tfsd_pkg::qstat_t     qstat,
  input  tfsd_pkg::alert_rec_t head,
  output logic                 pop,
  tfsd_out_if.source           alert
);
  import tfsd_pkg::*;

  logic [NUM_PAT-1:0] done;
  logic [NUM_PAT-1:0] remaining;
  logic [NUM_PAT-1:0] pick;
  logic [PAT_W-1:0]   pat;
  logic               last_beat;
  logic               load;

  logic              out_valid;
  logic [FLOW_W-1:0] out_flow;
  logic [PAT_W-1:0]  out_pat;
  logic              out_sev;
  logic [EVID_W-1:0] out_evid;
  logic              out_last;

  // lowest pending pattern goes first
  always_comb begin
    remaining = head.fire & ~done;
    pick      = '0;
    pat       = '0;
    for (int k = NUM_PAT - 1; k >= 0; k--) begin
      if (remaining[k]) begin
        pick    = '0;
        pick[k] = 1'b1;
        pat     = PAT_W'(k);
      end
    end
    last_beat = (remaining & ~pick) == '0;
  end

  assign load = qstat.valid && (!out_valid || alert.ready);
  assign pop  = load && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= last_beat ? '0 : (done | pick);
      end else if (alert.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_flow <= head.flow;
      out_pat  <= pat;
      out_sev  <= pat != PAT_FIN_SCAN;
      out_evid <= head.evid[pat];
      out_last <= last_beat;
    end
  end

  assign alert.valid          = out_valid;
  assign alert.alert_flow     = out_flow;
  assign alert.pattern        = out_pat;
  assign alert.severity       = out_sev;
  assign alert.evidence_count = out_evid;
  assign alert.last           = out_last;

  `TFSD_ASSERT_IMPL(a_done_clear_when_empty, clk, rst, !qstat.valid, done == '0)
  `TFSD_ASSERT_IMPL(a_head_has_pending, clk, rst, qstat.valid, remaining != '0)
  `TFSD_ASSERT_NEXT(a_pop_marks_last, clk, rst, pop, alert.valid && alert.last)

endmodule
